// ===== hdl/tlvd_pkg.sv =====
// Shared types and constants for the TLV chunk deframer.
// Holds the phase and result-kind codes, the result record and default sizes.
// Used by tlvd_parser, tlvd_fifo and tlv_chunk_deframer.
package tlvd_pkg;

    localparam int TAG_BYTES_DEF    = 4;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int OFFSET_BITS_DEF  = 16;
    localparam int LEN_BYTES        = 4;   // header opens with a 32-bit LE length
    localparam int FIFO_DEPTH       = 4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DROP    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHUNK   = 2'd0,
        KIND_OK      = 2'd1,
        KIND_TRUNC   = 2'd2,
        KIND_OVERRUN = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] tag;
        logic [15:0] offset;
        logic [31:0] length;
        logic [15:0] avail;
        logic        last;
    } t_result;

endpackage

// ===== hdl/tlvd_parser.sv =====
// Per-byte chunk walker of the TLV deframer: packet state plus the decode of one byte.
// Produces up to two result records for each accepted byte.
// Depends on tlvd_pkg.
module tlvd_parser #(
    parameter int TAG_BYTES    = tlvd_pkg::TAG_BYTES_DEF,
    parameter int HEADER_BYTES = tlvd_pkg::HEADER_BYTES_DEF,
    parameter int OFFSET_BITS  = tlvd_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_sop,
    input  logic [15:0]       i_plen,
    input  logic [7:0]        i_byte,
    output tlvd_pkg::t_result o_res0,
    output tlvd_pkg::t_result o_res1,
    output logic [1:0]        o_count
);
    import tlvd_pkg::*;

    t_phase                 r_phase, n_phase, e_phase;
    logic [15:0]            r_bl, n_bl, e_bl;
    logic [2:0]             r_hc, n_hc, e_hc;
    logic [31:0]            r_lg, n_lg, e_lg;
    logic [31:0]            r_tg, n_tg, e_tg;
    logic [15:0]            r_pl, n_pl, e_pl;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, e_pos;
    logic [OFFSET_BITS-1:0] r_cs, n_cs, e_cs;

    logic                   empty_start;
    logic [15:0]            step_bl;
    logic [15:0]            step_pl;
    logic [OFFSET_BITS-1:0] step_pos;
    logic [OFFSET_BITS-1:0] cs_new;
    logic [31:0]            cs_wide;
    logic [31:0]            lg_new;
    logic [31:0]            tg_new;
    logic                   in_hdr;
    logic                   trunc;
    logic                   hdr_done;
    logic                   overrun;

    // A start resets the walk before the byte itself is handled.
    assign empty_start = i_sop && (i_plen == 16'd0);

    always_comb begin
        e_phase = r_phase;
        e_bl    = r_bl;
        e_hc    = r_hc;
        e_lg    = r_lg;
        e_tg    = r_tg;
        e_pl    = r_pl;
        e_pos   = r_pos;
        e_cs    = r_cs;
        if (i_sop) begin
            e_phase = empty_start ? PH_IDLE : PH_HEADER;
            e_bl    = i_plen;
            e_hc    = '0;
            e_lg    = '0;
            e_tg    = '0;
            e_pl    = '0;
            e_pos   = '0;
            e_cs    = '0;
        end
    end

    assign step_bl  = e_bl - 16'd1;
    assign step_pl  = e_pl - 16'd1;
    assign step_pos = e_pos + OFFSET_BITS'(1);
    assign in_hdr   = (e_phase == PH_HEADER);
    assign trunc    = in_hdr && (e_hc == 3'd0) && (e_bl < 16'(HEADER_BYTES));
    assign cs_new   = (e_hc == 3'd0) ? e_pos : e_cs;
    assign cs_wide  = 32'(cs_new);

    // Steer the byte into its lane of the length or the tag.
    always_comb begin
        lg_new = e_lg;
        tg_new = e_tg;
        for (int k = 0; k < LEN_BYTES; k++) begin
            if (e_hc == 3'(k)) begin
                lg_new[8*k +: 8] = e_lg[8*k +: 8] | i_byte;
            end
        end
        for (int k = 0; k < TAG_BYTES; k++) begin
            if (e_hc == 3'(LEN_BYTES + k)) begin
                tg_new[8*k +: 8] = e_tg[8*k +: 8] | i_byte;
            end
        end
    end

    assign hdr_done = in_hdr && !trunc && (({1'b0, e_hc} + 4'd1) >= 4'(HEADER_BYTES));
    assign overrun  = hdr_done && (lg_new > {16'd0, step_bl});

    // Next state
    always_comb begin
        n_phase = e_phase;
        n_bl    = e_bl;
        n_hc    = e_hc;
        n_lg    = e_lg;
        n_tg    = e_tg;
        n_pl    = e_pl;
        n_pos   = e_pos;
        n_cs    = e_cs;
        case (e_phase)
            PH_DROP: begin
                n_bl  = step_bl;
                n_pos = step_pos;
                if (step_bl == 16'd0) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HEADER: begin
                n_bl  = step_bl;
                n_pos = step_pos;
                n_cs  = cs_new;
                if (trunc) begin
                    n_phase = (step_bl == 16'd0) ? PH_IDLE : PH_DROP;
                end else begin
                    n_lg = lg_new;
                    n_tg = tg_new;
                    n_hc = e_hc + 3'd1;
                    if (hdr_done) begin
                        if (overrun) begin
                            n_phase = (step_bl == 16'd0) ? PH_IDLE : PH_DROP;
                        end else begin
                            n_pl = lg_new[15:0];
                            if (lg_new[15:0] != 16'd0) begin
                                n_phase = PH_PAYLOAD;
                            end else if (step_bl == 16'd0) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_hc = '0;
                                n_lg = '0;
                                n_tg = '0;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pl  = step_pl;
                n_bl  = step_bl;
                n_pos = step_pos;
                if (step_pl == 16'd0) begin
                    if (step_bl == 16'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_HEADER;
                        n_hc    = '0;
                        n_lg    = '0;
                        n_tg    = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Results
    always_comb begin
        o_res0  = '0;
        o_res1  = '0;
        o_count = 2'd0;
        if (empty_start) begin
            o_res0.kind = KIND_OK;
            o_res0.last = 1'b1;
            o_count     = 2'd1;
        end else begin
            case (e_phase)
                PH_HEADER: begin
                    if (trunc) begin
                        o_res0.kind   = KIND_TRUNC;
                        o_res0.offset = cs_wide[15:0];
                        o_res0.avail  = e_bl;
                        o_res0.last   = 1'b1;
                        o_count       = 2'd1;
                    end else if (hdr_done) begin
                        o_res0.tag    = tg_new;
                        o_res0.offset = cs_wide[15:0];
                        o_res0.length = lg_new;
                        if (overrun) begin
                            o_res0.kind  = KIND_OVERRUN;
                            o_res0.avail = step_bl;
                            o_res0.last  = 1'b1;
                            o_count      = 2'd1;
                        end else if ((lg_new[15:0] == 16'd0) && (step_bl == 16'd0)) begin
                            o_res0.kind = KIND_CHUNK;
                            o_res1.kind = KIND_OK;
                            o_res1.last = 1'b1;
                            o_count     = 2'd2;
                        end else begin
                            o_res0.kind = KIND_CHUNK;
                            o_res0.last = 1'b1;
                            o_count     = 2'd1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if ((step_pl == 16'd0) && (step_bl == 16'd0)) begin
                        o_res0.kind = KIND_OK;
                        o_res0.last = 1'b1;
                        o_count     = 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bl    <= '0;
            r_hc    <= '0;
            r_lg    <= '0;
            r_tg    <= '0;
            r_pl    <= '0;
            r_pos   <= '0;
            r_cs    <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_bl    <= n_bl;
            r_hc    <= n_hc;
            r_lg    <= n_lg;
            r_tg    <= n_tg;
            r_pl    <= n_pl;
            r_pos   <= n_pos;
            r_cs    <= n_cs;
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_bl == 16'd0))
        else $error("idle with packet bytes still counted");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> ({1'b0, r_hc} < 4'(HEADER_BYTES)))
        else $error("header byte count past header size");

    a_pair_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_count == 2'd2) |-> ((o_res1.kind == KIND_OK) && !o_res0.last
                               && (o_res0.kind == KIND_CHUNK)))
        else $error("second result is not a packet-ok after a chunk");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_count != 2'd3))
        else $error("more than two results for one byte");

endmodule

// ===== hdl/tlvd_fifo.sv =====
// Small result queue of the TLV deframer: takes up to two records per cycle, gives one.
// Separates the byte input from a stalled result receiver.
// Depends on tlvd_pkg.
module tlvd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  tlvd_pkg::t_result i_res0,
    input  tlvd_pkg::t_result i_res1,
    output logic              o_ready,
    output logic              o_valid,
    output tlvd_pkg::t_result o_res,
    input  logic              i_pop
);
    import tlvd_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_result       r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          pop;

    // Room for a full pair of results keeps the input side free of the output.
    assign o_ready  = (r_count <= CW'(FIFO_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_res    = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_pop;
    assign n_wr_ptr = r_wr_ptr + PW'(i_push_cnt);
    assign n_rd_ptr = r_rd_ptr + PW'(pop);
    assign n_count  = r_count + CW'(i_push_cnt) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + PW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> o_ready)
        else $error("results pushed without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers differ on an empty queue");

endmodule

// ===== hdl/tlv_chunk_deframer.sv =====
// TLV chunk deframer: walks a byte stream of length-tagged chunks.
// Slave stream: one packet byte per word; tuser = start_of_packet, tdata bits
// 15:0 = packet_length (read only on a start), bits 23:16 = data_byte.
// Master stream: one result per word; tuser = result_kind (chunk found, packet
// ok, truncated header, payload overrun), tlast = last result of the byte,
// tdata = chunk_tag, chunk_offset, declared_length, bytes_available.
// Each chunk header is a 32-bit little-endian length and a tag; after each
// header a descriptor is sent and the payload is skipped. A malformed packet is
// reported once and the rest of it is dropped.
// Throughput: one byte per cycle while o_s_tready is high. A byte is decoded in the
// cycle it is taken and its results are registered into a four-entry queue that drives o_m_tvalid.
// A byte can yield two results (a zero-length chunk closing the packet), and
// the output gives one per cycle while i_m_tready is high, so the queue's free space sets o_s_tready.
// Reset (i_rst_n low, synchronous) empties the queue and returns to idle.
// When the receiver stalls, results wait in the queue; once fewer than two
// slots are free, o_s_tready drops until words are taken.
// Depends on tlvd_pkg, tlvd_parser and tlvd_fifo.
module tlv_chunk_deframer #(
    parameter int TAG_BYTES    = tlvd_pkg::TAG_BYTES_DEF,
    parameter int HEADER_BYTES = tlvd_pkg::HEADER_BYTES_DEF,
    parameter int OFFSET_BITS  = tlvd_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // packet_length[15:0], data_byte[23:16]
    input  logic        i_s_tuser,   // start_of_packet
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // chunk_tag[31:0], chunk_offset[47:32],
                                     // declared_length[79:48], bytes_available[95:80]
    output logic [1:0]  o_m_tuser,   // result_kind
    output logic        o_m_tlast    // last_result
);
    import tlvd_pkg::*;

    logic       accept;
    t_result    res0, res1, head;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;

    assign accept   = i_s_tvalid && o_s_tready;
    assign push_cnt = accept ? res_cnt : 2'd0;

    tlvd_parser #(
        .TAG_BYTES    (TAG_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_sop   (i_s_tuser),
        .i_plen  (i_s_tdata[15:0]),
        .i_byte  (i_s_tdata[23:16]),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_cnt)
    );

    tlvd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_ready    (o_s_tready),
        .o_valid    (o_m_tvalid),
        .o_res      (head),
        .i_pop      (i_m_tready)
    );

    assign o_m_tdata = {head.avail, head.length, head.offset, head.tag};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

// ===== tb/sv/tlvd_checker.sv =====
// Stream checker for tlv_chunk_deframer: watches the byte and result channels.
// Walks each accepted byte through its own chunk walker, queues the descriptors
// it expects and compares every result word field by field. Depends on tlvd_pkg.
module tlvd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // packet_length[15:0], data_byte[23:16]
    input  logic        i_s_tuser,   // start_of_packet
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,   // chunk_tag, chunk_offset, declared_length,
                                     // bytes_available
    input  logic [1:0]  i_m_tuser,   // result_kind
    input  logic        i_m_tlast,   // last_result
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlvd_pkg::*;

    t_phase      walk_phase;
    logic [15:0] bytes_left;
    logic [2:0]  hdr_idx;
    logic [31:0] len_acc;
    logic [31:0] tag_acc;
    logic [15:0] payload_left;
    logic [15:0] position;
    logic [15:0] chunk_start;

    t_result     descriptors_due[$];
    int          mismatches = 0;

    function automatic t_result pack_result(input t_kind kind, input logic [31:0] tag,
                                            input logic [15:0] offset,
                                            input logic [31:0] length,
                                            input logic [15:0] avail);
        t_result r;
        r.kind   = kind;
        r.tag    = tag;
        r.offset = offset;
        r.length = length;
        r.avail  = avail;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic clear_walker();
        walk_phase   = PH_IDLE;
        bytes_left   = '0;
        hdr_idx      = '0;
        len_acc      = '0;
        tag_acc      = '0;
        payload_left = '0;
        position     = '0;
        chunk_start  = '0;
    endtask

    task automatic begin_header();
        walk_phase = PH_HEADER;
        hdr_idx    = '0;
        len_acc    = '0;
        tag_acc    = '0;
    endtask

    // Advance the walker by one byte and queue the descriptors it yields.
    task automatic walk_byte(input logic sop, input logic [15:0] plen, input logic [7:0] b);
        t_result made [2];
        int      n;
        int      i;
        n = 0;
        if (sop) begin
            clear_walker();
            if (plen == 16'd0) begin
                // empty packet: report at once, walker stays idle
                made[0] = pack_result(KIND_OK, '0, '0, '0, '0);
                n = 1;
            end else begin
                bytes_left = plen;
                begin_header();
            end
        end
        case (walk_phase)
            PH_IDLE: ;
            PH_DROP: begin
                bytes_left = bytes_left - 16'd1;
                position   = position + 16'd1;
                if (bytes_left == 16'd0) walk_phase = PH_IDLE;
            end
            PH_HEADER: begin
                i = int'(hdr_idx);
                if (i == 0) begin
                    chunk_start = position;
                    if (bytes_left < 16'(HEADER_BYTES_DEF)) begin
                        made[n] = pack_result(KIND_TRUNC, '0, chunk_start, '0, bytes_left);
                        n++;
                        walk_phase = PH_DROP;
                    end
                end
                if (walk_phase == PH_HEADER) begin
                    if (i < LEN_BYTES) len_acc |= 32'(b) << (8 * i);
                    else tag_acc |= 32'(b) << (8 * (i - LEN_BYTES));
                    hdr_idx = 3'(i + 1);
                end
                bytes_left = bytes_left - 16'd1;
                position   = position + 16'd1;
                if (walk_phase == PH_DROP) begin
                    if (bytes_left == 16'd0) walk_phase = PH_IDLE;
                end else if (i + 1 >= HEADER_BYTES_DEF) begin
                    if (len_acc > 32'(bytes_left)) begin
                        made[n] = pack_result(KIND_OVERRUN, tag_acc, chunk_start, len_acc,
                                              bytes_left);
                        n++;
                        walk_phase = (bytes_left == 16'd0) ? PH_IDLE : PH_DROP;
                    end else begin
                        made[n] = pack_result(KIND_CHUNK, tag_acc, chunk_start, len_acc, '0);
                        n++;
                        payload_left = len_acc[15:0];
                        if (payload_left != 16'd0) begin
                            walk_phase = PH_PAYLOAD;
                        end else if (bytes_left == 16'd0) begin
                            // zero-length chunk closes the packet on the same byte
                            made[n] = pack_result(KIND_OK, '0, '0, '0, '0);
                            n++;
                            walk_phase = PH_IDLE;
                        end else begin
                            begin_header();
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                payload_left = payload_left - 16'd1;
                bytes_left   = bytes_left - 16'd1;
                position     = position + 16'd1;
                if (payload_left == 16'd0) begin
                    if (bytes_left == 16'd0) begin
                        made[n] = pack_result(KIND_OK, '0, '0, '0, '0);
                        n++;
                        walk_phase = PH_IDLE;
                    end else begin
                        begin_header();
                    end
                end
            end
            default: ;
        endcase
        if (n > 0) made[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) descriptors_due = {descriptors_due, made[k]};
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    task automatic check_word();
        t_result want;
        if (descriptors_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual kind %0d data %h",
                     $time, i_m_tuser, i_m_tdata);
        end else begin
            want = descriptors_due.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(i_m_tuser));
            compare_field("chunk_tag", want.tag, i_m_tdata[31:0]);
            compare_field("chunk_offset", 32'(want.offset), 32'(i_m_tdata[47:32]));
            compare_field("declared_length", want.length, i_m_tdata[79:48]);
            compare_field("bytes_available", 32'(want.avail), 32'(i_m_tdata[95:80]));
            compare_field("last_result", 32'(want.last), 32'(i_m_tlast));
        end
    endtask

    // Check the outgoing word before walking the incoming byte: a byte's
    // results cannot leave in the cycle the byte is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_walker();
            descriptors_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_word();
            if (i_s_tvalid && i_s_tready) walk_byte(i_s_tuser, i_s_tdata[15:0], i_s_tdata[23:16]);
        end
        o_pending    <= descriptors_due.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the tlv_chunk_deframer testbench: clock, reset, byte stimulus, output stall.
// Builds chunk packets (good, truncated, overrun, abandoned, short, noise) and
// gives the verdict from tlvd_checker's mismatch count. Depends on tlvd_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // packet_length[15:0], data_byte[23:16]
    logic        i_s_tuser = 1'b0; // start_of_packet
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;        // chunk_tag[31:0], chunk_offset[47:32],
                                   // declared_length[79:48], bytes_available[95:80]
    logic [1:0]  o_m_tuser;        // result_kind
    logic        o_m_tlast;        // last_result

    int          mismatch_count;
    int          words_pending;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;
    logic [7:0]  body[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tlv_chunk_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    tlvd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatch_count),
        .o_pending    (words_pending)
    );

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_byte(input logic sop, input logic [15:0] plen, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= sop;
        i_s_tdata  <= {b, plen};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic append_byte(input logic [7:0] v);
        body = {body, v};
    endtask

    // Header: 32-bit LE length, then tag; payload bytes are random.
    task automatic add_chunk(input logic [31:0] len_field, input logic [31:0] tag,
                             input int payload_n);
        for (int k = 0; k < 4; k++) append_byte(len_field[8*k +: 8]);
        for (int k = 0; k < 4; k++) append_byte(tag[8*k +: 8]);
        repeat (payload_n) append_byte(8'($urandom));
    endtask

    task automatic send_packet(input logic [15:0] plen, input int n_send);
        for (int k = 0; k < n_send; k++)
            push_byte(k == 0, (k == 0) ? plen : 16'($urandom), body[k]);
    endtask

    // Hold the byte channel until every expected word has left.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int pick_payload_len();
        if ($urandom_range(9) < 8) return $urandom_range(0, 6);
        return $urandom_range(7, 40);
    endfunction

    task automatic random_packet();
        int          shape;
        int          n_send;
        int          tail;
        logic [31:0] len_field;
        logic [15:0] plen;
        body.delete();
        shape = $urandom_range(99);
        if (shape >= 92) begin
            // loose bytes, now and then a stray start
            repeat ($urandom_range(1, 12))
                push_byte($urandom_range(7) == 0, 16'($urandom_range(0, 40)), 8'($urandom));
            return;
        end
        repeat ($urandom_range(1, 4)) begin
            tail = pick_payload_len();
            add_chunk(32'(tail), $urandom, tail);
        end
        if (shape >= 50 && shape < 62) begin
            // too few bytes left for another header
            repeat ($urandom_range(1, 7)) append_byte(8'($urandom));
        end else if (shape >= 62 && shape < 74) begin
            // last chunk claims more than is left
            tail = $urandom_range(0, 6);
            len_field = $urandom_range(1) ? 32'(tail + $urandom_range(1, 20))
                                          : {1'b1, 31'($urandom)};
            add_chunk(len_field, $urandom, tail);
        end
        plen   = 16'(body.size());
        n_send = body.size();
        if (shape >= 74 && shape < 84) begin
            // cut short; the next start abandons it
            plen   = plen + 16'($urandom_range(0, 300));
            n_send = $urandom_range(1, body.size());
        end else if (shape >= 84) begin
            plen = 16'($urandom_range(1, body.size()));
        end
        send_packet(plen, n_send);
    endtask

    initial begin
        int phase_start;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte outside any packet, then an empty packet
        push_byte(1'b0, 16'hFFFF, 8'hFF);
        push_byte(1'b1, 16'h0000, 8'h00);
        // header truncated at the very start
        body.delete();
        repeat (3) append_byte(8'($urandom));
        send_packet(16'd3, 3);
        // zero-length chunk that closes the packet: two words on one byte
        body.delete();
        add_chunk(32'd0, 32'hFFFF_FFFF, 0);
        send_packet(16'd8, 8);
        // overrun on the last header byte with nothing left
        body.delete();
        add_chunk(32'hFFFF_FFFF, 32'h0000_0000, 0);
        send_packet(16'd8, 8);
        // longest packet, abandoned in its payload by a new start
        body.delete();
        add_chunk(32'd65527, $urandom, 2);
        send_packet(16'hFFFF, 10);
        body.delete();
        add_chunk(32'd1, $urandom, 1);
        send_packet(16'd9, 9);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 87; end
                default: begin send_idle_pct = 31; recv_stall_pct <= 31; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_packet();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
